FILE: hdl/mdew_pkg.sv
package mdew_pkg;

	localparam int PIX_W  = 8;
	localparam int RAD_W  = 3;
	localparam int WID_W  = 11;
	localparam int HGT_W  = 13;
	localparam int ROW_W  = 12;
	localparam int DLY_W  = 14;
	localparam int GAP_W  = 15;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [PIX_W-1:0] PIX_HI = 8'hFF;
	localparam logic [PIX_W-1:0] PIX_LO = 8'h00;
	localparam logic [HGT_W-1:0] HEIGHT_MAX = 13'd4096;

	typedef enum logic {
		MODE_DILATE = 1'b0,
		MODE_ERODE  = 1'b1
	} mode_t;

	typedef enum logic {
		ACT_PIXEL = 1'b0,
		ACT_FLUSH = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		REG_MODE   = 2'd0,
		REG_RADIUS = 2'd1,
		REG_WIDTH  = 2'd2,
		REG_HEIGHT = 2'd3
	} reg_idx_t;

	// effective (saturated) configuration
	typedef struct packed {
		mode_t             mode;
		logic [RAD_W-1:0]  radius;
		logic [WID_W-1:0]  width;
		logic [HGT_W-1:0]  height;
		logic [DLY_W-1:0]  delay;
	} cfg_t;

	// one result being launched into the output stage
	typedef struct packed {
		logic              valid;
		logic              interior;
		logic              last;
		logic              pix_fwd;
		logic [PIX_W-1:0]  pix;
		logic              hit_fwd;
		logic [PIX_W-1:0]  target;
	} emit_t;

endpackage

FILE: hdl/morphology_dilate_erode_window.sv
// A result passes the s1 stage and the output register after the item releasing it.
// Throughput: one item per cycle unless the output stalls; results trail the pixel
// stream by R*W+R items, and flush items release the remaining tail one per cycle.
// Banked hit-flag buffers (one per window row) give the whole window column at once.
// Reset (arst_n, async, active low) restores mode dilate, R=1, 640x480 and clears all
// frame counters; line buffer contents are not cleared.
module morphology_dilate_erode_window
	import mdew_pkg::*;
#(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_RADIUS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [PIX_W-1:0]   s_axis_tdata,  // [7:0] pixel_in
	input  logic               s_axis_tuser,  // [0] action
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [PIX_W-1:0]   m_axis_tdata,  // [7:0] pixel_out
	output logic               m_axis_tlast
);

	localparam int L  = 2 * MAX_RADIUS + 1;
	localparam int BW = $clog2(L);
	localparam int CW = $clog2(MAX_WIDTH);

	cfg_t             cfg;
	logic             cfg_wr;
	logic             acc;
	emit_t            emit;
	logic [L-1:0]     win_mask;
	logic             pix_we;
	logic [BW+CW-1:0] pix_waddr, pix_raddr;
	logic             rd_en;
	logic [L-1:0]     hit_we;
	logic [CW-1:0]    hit_waddr, hit_raddr;
	logic             hit_wdata;
	logic [L-1:0]     hit_rd;
	logic [PIX_W-1:0] pix_rd;

	assign acc = s_axis_tvalid && s_axis_tready;

	mdew_cfg #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_RADIUS(MAX_RADIUS)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg),
		.wr     (cfg_wr)
	);

	mdew_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_RADIUS(MAX_RADIUS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cfg_wr   (cfg_wr),
		.acc      (acc),
		.action   (action_t'(s_axis_tuser)),
		.pixel    (s_axis_tdata),
		.emit     (emit),
		.win_mask (win_mask),
		.pix_we   (pix_we),
		.pix_waddr(pix_waddr),
		.rd_en    (rd_en),
		.pix_raddr(pix_raddr),
		.hit_we   (hit_we),
		.hit_waddr(hit_waddr),
		.hit_wdata(hit_wdata),
		.hit_raddr(hit_raddr)
	);

	// pixel line store: L rows, addressed {row bank, column}
	mdew_ram #(
		.WIDTH(PIX_W),
		.DEPTH(L * (2 ** CW))
	) u_pix_ram (
		.clk  (clk),
		.we   (pix_we),
		.waddr(pix_waddr),
		.wdata(s_axis_tdata),
		.re   (rd_en),
		.raddr(pix_raddr),
		.rdata(pix_rd)
	);

	// one bank of horizontal hit flags per window row
	for (genvar b = 0; b < L; b++) begin : g_hit_bank
		mdew_ram #(
			.WIDTH(1),
			.DEPTH(MAX_WIDTH)
		) u_hit_ram (
			.clk  (clk),
			.we   (hit_we[b]),
			.waddr(hit_waddr),
			.wdata(hit_wdata),
			.re   (rd_en),
			.raddr(hit_raddr),
			.rdata(hit_rd[b])
		);
	end

	mdew_out #(
		.L(L)
	) u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.emit    (emit),
		.win_mask(win_mask),
		.hit_rd  (hit_rd),
		.pix_rd  (pix_rd),
		.ready   (s_axis_tready),
		.m_tvalid(m_axis_tvalid),
		.m_tready(m_axis_tready),
		.m_tdata (m_axis_tdata),
		.m_tlast (m_axis_tlast)
	);

`ifndef SYNTH
	a_emit_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> (s_axis_tvalid && s_axis_tready))
		else $error("result launched without an accepted item");

	a_pix_fwd_radius: assert property (@(posedge clk) disable iff (!arst_n)
		emit.pix_fwd |-> (cfg.radius == '0))
		else $error("pixel forwarding with nonzero window delay");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled while output side can move");
`endif

endmodule

FILE: hdl/mdew_ram.sv
module mdew_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

FILE: hdl/mdew_cfg.sv
module mdew_cfg
	import mdew_pkg::*;
#(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_RADIUS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg,
	output logic               wr
);

	localparam logic [RAD_W-1:0] RSAT =
		RAD_W'(MAX_RADIUS > (2**RAD_W - 1) ? (2**RAD_W - 1) : MAX_RADIUS);
	localparam logic [WID_W-1:0] WSAT =
		WID_W'(MAX_WIDTH > (2**WID_W - 1) ? (2**WID_W - 1) : MAX_WIDTH);

	function automatic logic [RAD_W-1:0] sat_r(input logic [RAD_W-1:0] v);
		sat_r = (v > RSAT) ? RSAT : v;
	endfunction

	function automatic logic [WID_W-1:0] sat_w(input logic [WID_W-1:0] v);
		if (v == '0)
			sat_w = WID_W'(1);
		else
			sat_w = (v > WSAT) ? WSAT : v;
	endfunction

	function automatic logic [HGT_W-1:0] sat_h(input logic [HGT_W-1:0] v);
		if (v == '0)
			sat_h = HGT_W'(1);
		else
			sat_h = (v > HEIGHT_MAX) ? HEIGHT_MAX : v;
	endfunction

	// items held back before the first result: R rows plus R pixels
	function automatic logic [DLY_W-1:0] calc_delay(input logic [RAD_W-1:0] r,
		input logic [WID_W-1:0] w);
		calc_delay = DLY_W'(r) * DLY_W'(w) + DLY_W'(r);
	endfunction

	mode_t            mode_q;
	logic [RAD_W-1:0] radius_q;
	logic [WID_W-1:0] width_q;
	logic [HGT_W-1:0] height_q;
	cfg_t             cfg_q;

	reg_idx_t         idx;
	mode_t            n_mode;
	logic [RAD_W-1:0] n_radius;
	logic [WID_W-1:0] n_width;
	logic [HGT_W-1:0] n_height;
	logic [RAD_W-1:0] e_radius;
	logic [WID_W-1:0] e_width;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[3:2]);

	always_comb begin
		n_mode   = mode_q;
		n_radius = radius_q;
		n_width  = width_q;
		n_height = height_q;
		if (wr) begin
			unique case (idx)
				REG_MODE:   n_mode   = mode_t'(pwdata[0]);
				REG_RADIUS: n_radius = pwdata[RAD_W-1:0];
				REG_WIDTH:  n_width  = pwdata[WID_W-1:0];
				REG_HEIGHT: n_height = pwdata[HGT_W-1:0];
			endcase
		end
		e_radius = sat_r(n_radius);
		e_width  = sat_w(n_width);
	end

	always_comb begin
		unique case (idx)
			REG_MODE:   prdata = PDATA_W'(mode_q);
			REG_RADIUS: prdata = PDATA_W'(radius_q);
			REG_WIDTH:  prdata = PDATA_W'(width_q);
			REG_HEIGHT: prdata = PDATA_W'(height_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_DILATE;
			radius_q      <= RAD_W'(1);
			width_q       <= WID_W'(640);
			height_q      <= HGT_W'(480);
			cfg_q.mode    <= MODE_DILATE;
			cfg_q.radius  <= sat_r(RAD_W'(1));
			cfg_q.width   <= sat_w(WID_W'(640));
			cfg_q.height  <= sat_h(HGT_W'(480));
			cfg_q.delay   <= calc_delay(sat_r(RAD_W'(1)), sat_w(WID_W'(640)));
		end else if (wr) begin
			mode_q        <= n_mode;
			radius_q      <= n_radius;
			width_q       <= n_width;
			height_q      <= n_height;
			cfg_q.mode    <= n_mode;
			cfg_q.radius  <= e_radius;
			cfg_q.width   <= e_width;
			cfg_q.height  <= sat_h(n_height);
			cfg_q.delay   <= calc_delay(e_radius, e_width);
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/mdew_ctrl.sv
module mdew_ctrl
	import mdew_pkg::*;
#(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_RADIUS = 4,
	localparam int L  = 2 * MAX_RADIUS + 1,
	localparam int BW = $clog2(L),
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             cfg_wr,
	input  logic             acc,
	input  action_t          action,
	input  logic [PIX_W-1:0] pixel,
	output emit_t            emit,
	output logic [L-1:0]     win_mask,
	output logic             pix_we,
	output logic [BW+CW-1:0] pix_waddr,
	output logic             rd_en,
	output logic [BW+CW-1:0] pix_raddr,
	output logic [L-1:0]     hit_we,
	output logic [CW-1:0]    hit_waddr,
	output logic             hit_wdata,
	output logic [CW-1:0]    hit_raddr
);

	localparam int HW = 2 * MAX_RADIUS;
	localparam int KW = $clog2(HW + 1);
	localparam int DW = BW + 1;

	logic [CW-1:0]    in_col_q, out_col_q;
	logic [ROW_W-1:0] in_row_q, out_row_q;
	logic [BW-1:0]    in_bank_q, out_bank_q;
	logic [GAP_W-1:0] gap_q;
	logic             done_q;
	logic [HW-1:0]    hwin_q;

	logic [PIX_W-1:0] target;
	logic             cmp, hhit;
	logic             pix_take, pix_emit, do_emit;
	logic             in_col_end, in_last, out_col_end, out_last;
	logic [GAP_W-1:0] gap_inc;
	logic             hit_wen, hit_match, fwd_bit, in_win;
	logic [DW-1:0]    bank_off;

	assign target   = (cfg.mode == MODE_ERODE) ? PIX_LO : PIX_HI;
	assign cmp      = (pixel == target);

	assign pix_take = acc && (action == ACT_PIXEL) && !done_q;
	assign gap_inc  = gap_q + 1'b1;
	assign pix_emit = pix_take && (gap_inc > GAP_W'(cfg.delay));
	assign do_emit  = pix_emit || (acc && (action == ACT_FLUSH) && done_q);

	assign in_col_end  = 16'(in_col_q) == 16'(cfg.width) - 16'd1;
	assign in_last     = in_col_end && (HGT_W'(in_row_q) == cfg.height - 1'b1);
	assign out_col_end = 16'(out_col_q) == 16'(cfg.width) - 16'd1;
	assign out_last    = out_col_end && (HGT_W'(out_row_q) == cfg.height - 1'b1);

	// horizontal hit: any compare among the last 2R+1 pixels received,
	// stored against the column R behind the incoming one
	always_comb begin
		hhit = cmp;
		for (int k = 0; k < HW; k++)
			hhit = hhit | (hwin_q[k] && (KW'(k) < KW'({cfg.radius, 1'b0})));
	end

	assign hit_wen   = pix_take && (16'(in_col_q) >= 16'(cfg.radius));
	assign hit_waddr = CW'(16'(in_col_q) - 16'(cfg.radius));
	assign hit_wdata = hhit;
	assign hit_raddr = out_col_q;
	assign hit_match = hit_wen && (hit_waddr == out_col_q);

	// banks of rows r-R..r+R around the output row, cyclic over L banks
	always_comb begin
		fwd_bit  = 1'b0;
		bank_off = '0;
		in_win   = 1'b0;
		for (int b = 0; b < L; b++) begin
			if (BW'(b) >= out_bank_q)
				bank_off = DW'(b) - DW'(out_bank_q);
			else
				bank_off = DW'(b + L) - DW'(out_bank_q);
			in_win = (bank_off <= DW'(cfg.radius))
				|| (bank_off >= DW'(L) - DW'(cfg.radius));
			hit_we[b] = hit_wen && (BW'(b) == in_bank_q);
			if (hit_match && (BW'(b) == in_bank_q)) begin
				win_mask[b] = 1'b0;
				fwd_bit     = in_win && hhit;
			end else begin
				win_mask[b] = in_win;
			end
		end
	end

	assign pix_we    = pix_take;
	assign pix_waddr = {in_bank_q, in_col_q};
	assign rd_en     = do_emit;
	assign pix_raddr = {out_bank_q, out_col_q};

	always_comb begin
		emit.valid    = do_emit;
		emit.interior = (HGT_W'(out_row_q) >= HGT_W'(cfg.radius))
			&& (HGT_W'(out_row_q) + HGT_W'(cfg.radius) < cfg.height)
			&& (16'(out_col_q) >= 16'(cfg.radius))
			&& (16'(out_col_q) + 16'(cfg.radius) < 16'(cfg.width));
		emit.last     = out_last;
		emit.pix_fwd  = do_emit && pix_take && (pix_waddr == pix_raddr);
		emit.pix      = pixel;
		emit.hit_fwd  = do_emit && fwd_bit;
		emit.target   = target;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_bank_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_bank_q <= '0;
			gap_q      <= '0;
			done_q     <= 1'b0;
			hwin_q     <= '0;
		end else if (cfg_wr) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_bank_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_bank_q <= '0;
			gap_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			if (pix_take)
				hwin_q <= {hwin_q[HW-2:0], cmp};
			if (do_emit && out_last) begin
				// last pixel of the frame out: everything starts over
				in_col_q   <= '0;
				in_row_q   <= '0;
				in_bank_q  <= '0;
				out_col_q  <= '0;
				out_row_q  <= '0;
				out_bank_q <= '0;
				gap_q      <= '0;
				done_q     <= 1'b0;
			end else begin
				if (pix_take) begin
					if (in_last) begin
						done_q <= 1'b1;
					end else if (in_col_end) begin
						in_col_q  <= '0;
						in_row_q  <= in_row_q + 1'b1;
						in_bank_q <= (in_bank_q == BW'(L - 1)) ? '0 : in_bank_q + 1'b1;
					end else begin
						in_col_q <= in_col_q + 1'b1;
					end
					if (!pix_emit)
						gap_q <= gap_inc;
				end
				if (do_emit) begin
					if (out_col_end) begin
						out_col_q  <= '0;
						out_row_q  <= out_row_q + 1'b1;
						out_bank_q <= (out_bank_q == BW'(L - 1)) ? '0 : out_bank_q + 1'b1;
					end else begin
						out_col_q <= out_col_q + 1'b1;
					end
				end
			end
		end
	end

endmodule

FILE: hdl/mdew_out.sv
module mdew_out
	import mdew_pkg::*;
#(
	parameter int L = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  emit_t            emit,
	input  logic [L-1:0]     win_mask,
	input  logic [L-1:0]     hit_rd,
	input  logic [PIX_W-1:0] pix_rd,
	output logic             ready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [PIX_W-1:0] m_tdata,
	output logic             m_tlast
);

	logic             valid_s1;
	emit_t            info_s1;
	logic [L-1:0]     mask_s1;
	logic             out_valid_q;
	logic [PIX_W-1:0] out_pix_q;
	logic             out_last_q;

	logic             free, move, hit;
	logic [PIX_W-1:0] pix, result;

	assign free  = !out_valid_q || m_tready;
	assign move  = valid_s1 && free;
	assign ready = !valid_s1 || free;

	// RAM read data arrives with the s1 stage; pending writes are forwarded
	assign hit    = (|(mask_s1 & hit_rd)) || info_s1.hit_fwd;
	assign pix    = info_s1.pix_fwd ? info_s1.pix : pix_rd;
	assign result = (info_s1.interior && hit) ? info_s1.target : pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit.valid)
				valid_s1 <= 1'b1;
			else if (move)
				valid_s1 <= 1'b0;
			if (move)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			info_s1 <= emit;
			mask_s1 <= win_mask;
		end
		if (move) begin
			out_pix_q  <= result;
			out_last_q <= info_s1.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_pix_q;
	assign m_tlast  = out_last_q;

endmodule

FILE: tb/morphology_dilate_erode_window_test.sv
`timescale 1ns / 1ps

module morphology_dilate_erode_window_test;
	import mdew_pkg::*;

	localparam int MAX_W = 1024;
	localparam int MAX_R = 4;
	localparam int MAX_H = 4096;
	localparam int LINE_ROWS = 2 * MAX_R + 1;
	localparam int SETTLE_CYCLES = 6;
	localparam int END_CYCLES = 20;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 450;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_VALUE
	} chk_t;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             last;
	} morph_res_t;

	// val is the pixel for an item row, the register value for a config row
	typedef struct packed {
		row_kind_t          kind;
		action_t            act;
		reg_idx_t           idx;
		logic [PDATA_W-1:0] val;
		chk_t               chk;
		morph_res_t         res;
	} dir_row_t;

	localparam dir_row_t DIR_TAB [30] = '{
		// flush with no frame received
		'{ROW_ITEM, ACT_FLUSH, REG_MODE,   32'h00, CHK_NONE,  {8'h00, 1'b0}},
		'{ROW_CFG,  ACT_PIXEL, REG_WIDTH,  32'd1,  CHK_MODEL, {8'h00, 1'b0}},
		'{ROW_CFG,  ACT_PIXEL, REG_HEIGHT, 32'd1,  CHK_MODEL, {8'h00, 1'b0}},
		// 1x1 frame, R=1: result only comes out on the flush
		'{ROW_ITEM, ACT_PIXEL, REG_MODE,   32'hFF, CHK_NONE,  {8'h00, 1'b0}},
		'{ROW_ITEM, ACT_FLUSH, REG_MODE,   32'h00, CHK_VALUE, {8'hFF, 1'b1}},
		// pixel after the frame is complete is dropped
		'{ROW_ITEM, ACT_PIXEL, REG_MODE,   32'h80, CHK_NONE,  {8'h00, 1'b0}},
		'{ROW_ITEM, ACT_PIXEL, REG_MODE,   32'h11, CHK_NONE,  {8'h00, 1'b0}},
		'{ROW_ITEM, ACT_FLUSH, REG_MODE,   32'h00, CHK_VALUE, {8'h80, 1'b1}},
		// R=0: no delay
		'{ROW_CFG,  ACT_PIXEL, REG_RADIUS, 32'd0,  CHK_MODEL, {8'h00, 1'b0}},
		'{ROW_ITEM, ACT_PIXEL, REG_MODE,   32'h00, CHK_VALUE, {8'h00, 1'b1}},
		'{ROW_ITEM, ACT_PIXEL, REG_MODE,   32'hFF, CHK_VALUE, {8'hFF, 1'b1}},
		'{ROW_CFG,  ACT_PIXEL, REG_WIDTH,  32'd3,  CHK_MODEL, {8'h00, 1'b0}},
		'{ROW_CFG,  ACT_PIXEL, REG_HEIGHT, 32'd3,  CHK_MODEL, {8'h00, 1'b0}},
		'{ROW_CFG,  ACT_PIXEL, REG_RADIUS, 32'd1,  CHK_MODEL, {8'h00, 1'b0}},
		// partial frame, then a register write aborts it
		'{ROW_ITEM, ACT_PIXEL, REG_MODE,   32'hFF, CHK_NONE,  {8'h00, 1'b0}},
		'{ROW_ITEM, ACT_PIXEL, REG_MODE,   32'h0A, CHK_NONE,  {8'h00, 1'b0}},
		'{ROW_CFG,  ACT_PIXEL, REG_MODE,   32'd1,  CHK_MODEL, {8'h00, 1'b0}},
		// 3x3 erode, zero in the corner reaches the center
		'{ROW_ITEM, ACT_PIXEL, REG_MODE,   32'hC8, CHK_MODEL, {8'h00, 1'b0}},
		'{ROW_ITEM, ACT_PIXEL, REG_MODE,   32'hC8, CHK_MODEL, {8'h00, 1'b0}},
		'{ROW_ITEM, ACT_PIXEL, REG_MODE,   32'hC8, CHK_MODEL, {8'h00, 1'b0}},
		'{ROW_ITEM, ACT_PIXEL, REG_MODE,   32'hC8, CHK_MODEL, {8'h00, 1'b0}},
		'{ROW_ITEM, ACT_PIXEL, REG_MODE,   32'h4D, CHK_MODEL, {8'h00, 1'b0}},
		'{ROW_ITEM, ACT_PIXEL, REG_MODE,   32'hC8, CHK_MODEL, {8'h00, 1'b0}},
		'{ROW_ITEM, ACT_PIXEL, REG_MODE,   32'hC8, CHK_MODEL, {8'h00, 1'b0}},
		'{ROW_ITEM, ACT_PIXEL, REG_MODE,   32'hC8, CHK_MODEL, {8'h00, 1'b0}},
		'{ROW_ITEM, ACT_PIXEL, REG_MODE,   32'h00, CHK_MODEL, {8'h00, 1'b0}},
		'{ROW_ITEM, ACT_FLUSH, REG_MODE,   32'h00, CHK_MODEL, {8'h00, 1'b0}},
		'{ROW_ITEM, ACT_FLUSH, REG_MODE,   32'h00, CHK_MODEL, {8'h00, 1'b0}},
		'{ROW_ITEM, ACT_FLUSH, REG_MODE,   32'h00, CHK_MODEL, {8'h00, 1'b0}},
		'{ROW_ITEM, ACT_FLUSH, REG_MODE,   32'h00, CHK_MODEL, {8'h00, 1'b0}}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [PIX_W-1:0]   s_axis_tdata = '0;  // [7:0] pixel_in
	logic               s_axis_tuser = 1'b0; // [0] action
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [PIX_W-1:0]   m_axis_tdata;       // [7:0] pixel_out
	logic               m_axis_tlast;

	morphology_dilate_erode_window dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow of the block's configuration and frame state
	mode_t            cur_mode = MODE_DILATE;
	logic [RAD_W-1:0] cur_rad = 3'd1;
	logic [WID_W-1:0] cur_wid = 11'd640;
	logic [HGT_W-1:0] cur_hgt = 13'd480;
	logic [PIX_W-1:0] pix_store [LINE_ROWS * MAX_W];
	logic [9:0]       in_col = '0;
	logic [11:0]      in_row = '0;
	logic [9:0]       out_col = '0;
	logic [11:0]      out_row = '0;
	bit               in_done = 1'b0;

	morph_res_t expected_px [$];
	int         errors = 0;
	int         items_used = 0;
	int         burst_left = 0;
	int         idle_cycles = 0;
	int         ready_run = 0;
	logic       ready_lvl = 1'b1;

	function automatic int unsigned eff_w();
		if (cur_wid == 0) return 1;
		return (cur_wid > MAX_W) ? MAX_W : cur_wid;
	endfunction

	function automatic int unsigned eff_h();
		if (cur_hgt == 0) return 1;
		return (cur_hgt > MAX_H) ? MAX_H : cur_hgt;
	endfunction

	function automatic int unsigned eff_r();
		return (cur_rad > MAX_R) ? MAX_R : cur_rad;
	endfunction

	function automatic int slot(int unsigned row, int unsigned col);
		return (row % LINE_ROWS) * MAX_W + col;
	endfunction

	function automatic void restart_frame();
		in_col = '0;
		in_row = '0;
		out_col = '0;
		out_row = '0;
		in_done = 1'b0;
	endfunction

	// filtered value of the pixel at the output position, then advance it
	function automatic morph_res_t next_output();
		int unsigned w, h, rad, r, c;
		logic [PIX_W-1:0] target;
		bit hit;
		morph_res_t res;
		w = eff_w();
		h = eff_h();
		rad = eff_r();
		r = out_row;
		c = out_col;
		res.pix = pix_store[slot(r, c)];
		target = (cur_mode == MODE_ERODE) ? PIX_LO : PIX_HI;
		hit = 1'b0;
		if (r >= rad && r + rad < h && c >= rad && c + rad < w) begin
			for (int i = 0; i <= 2 * rad; i++)
				for (int j = 0; j <= 2 * rad; j++)
					if (pix_store[slot(r - rad + j, c - rad + i)] == target) hit = 1'b1;
		end
		if (hit) res.pix = target;
		res.last = (r == h - 1 && c == w - 1);
		if (res.last) begin
			restart_frame();
		end else if (out_col + 1 >= w) begin
			out_col = '0;
			out_row++;
		end else begin
			out_col++;
		end
		return res;
	endfunction

	function automatic bit predict_item(action_t act, logic [PIX_W-1:0] pix,
			output morph_res_t res);
		int unsigned w, h, rad, received, emitted;
		w = eff_w();
		h = eff_h();
		rad = eff_r();
		res = '0;
		if (act == ACT_FLUSH) begin
			if (!in_done) return 1'b0;
			res = next_output();
			return 1'b1;
		end
		if (in_done) return 1'b0;
		pix_store[slot(in_row, in_col)] = pix;
		if (in_row == h - 1 && in_col == w - 1) begin
			in_done = 1'b1;
		end else if (in_col + 1 >= w) begin
			in_col = '0;
			in_row++;
		end else begin
			in_col++;
		end
		received = in_done ? w * h : in_row * w + in_col;
		emitted = out_row * w + out_col;
		if (received > emitted + rad * w + rad) begin
			res = next_output();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 9))
			0, 1: return PIX_HI;
			2, 3: return PIX_LO;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	task automatic send_item(action_t act, logic [PIX_W-1:0] pix, chk_t chk,
			morph_res_t typed);
		int gap;
		bit made;
		morph_res_t res;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 60);
		end
		burst_left--;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= pix;
		do @(posedge clk); while (!s_axis_tready);
		if ((act == ACT_PIXEL) != in_done) items_used++;
		made = predict_item(act, pix, res);
		if (chk == CHK_VALUE) expected_px.push_back(typed);
		else if (chk == CHK_MODEL && made) expected_px.push_back(res);
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_px.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [PDATA_W-1:0] val);
		hold_until_drained();
		// a pixel with no result may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_MODE: cur_mode = mode_t'(val[0]);
			REG_RADIUS: cur_rad = val[RAD_W-1:0];
			REG_WIDTH: cur_wid = val[WID_W-1:0];
			REG_HEIGHT: cur_hgt = val[HGT_W-1:0];
			default: ;
		endcase
		restart_frame();
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// mostly whole frames; some noisy, some cut short by the next setting
	task automatic run_frame(bit clean_only, output bit aborted);
		int kind, npix, cut, sent;
		kind = clean_only ? 9 : $urandom_range(0, 9);
		npix = eff_w() * eff_h();
		aborted = 1'b0;
		if (kind == 0 && npix > 1) begin
			cut = $urandom_range(1, npix - 1);
			repeat (cut) send_item(ACT_PIXEL, rand_pixel(), CHK_MODEL, '0);
			aborted = 1'b1;
			return;
		end
		// with R=0 the frame restarts on its last pixel, so count pixels
		sent = 0;
		while (sent < npix) begin
			if (kind == 1 && $urandom_range(0, 7) == 0) begin
				send_item(ACT_FLUSH, PIX_W'($urandom), CHK_MODEL, '0);
			end else begin
				send_item(ACT_PIXEL, rand_pixel(), CHK_MODEL, '0);
				sent++;
			end
		end
		while (in_done) begin
			if (kind == 1 && $urandom_range(0, 5) == 0)
				send_item(ACT_PIXEL, rand_pixel(), CHK_MODEL, '0);
			else
				send_item(ACT_FLUSH, PIX_W'($urandom), CHK_MODEL, '0);
		end
		if ($urandom_range(0, 5) == 0) hold_until_drained();
	endtask

	task automatic run_phase(int phase, bit extreme);
		int rad_raw, wid_raw, hgt_raw, nframes;
		bit aborted;
		rad_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
		wid_raw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
		hgt_raw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
		case (phase)
			2: begin
				wid_raw = 12;
				hgt_raw = 9;
				rad_raw = 4;
			end
			5: begin
				wid_raw = 0;
				hgt_raw = 0;
				rad_raw = 0;
			end
			8: begin
				wid_raw = 9;
				hgt_raw = 9;
				rad_raw = 7;
			end
			default: ;
		endcase
		if (phase < 3 || $urandom_range(0, 3) != 0) write_reg(REG_MODE, $urandom);
		if (phase < 3 || extreme || $urandom_range(0, 3) != 0)
			write_reg(REG_RADIUS, ($urandom & ~32'h7) | rad_raw);
		write_reg(REG_WIDTH, ($urandom & ~32'h7FF) | wid_raw);
		write_reg(REG_HEIGHT, ($urandom & ~32'h1FFF) | hgt_raw);
		nframes = extreme ? 1 : $urandom_range(1, 4);
		for (int f = 0; f < nframes; f++) begin
			run_frame(extreme, aborted);
			if (aborted) break;
		end
	endtask

	always @(negedge clk) begin
		if (ready_run == 0) begin
			ready_lvl = ($urandom_range(0, 2) != 0);
			ready_run = ready_lvl ? $urandom_range(1, 30) : $urandom_range(1, 8);
		end
		ready_run--;
		m_axis_tready <= ready_lvl;
	end

	always @(posedge clk) begin
		morph_res_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_px.size() == 0) begin
				$display("%0t: result with none expected, pixel_out %h frame_last %b",
					$time, m_axis_tdata, m_axis_tlast);
				errors++;
			end else begin
				exp_r = expected_px.pop_front();
				if (m_axis_tdata !== exp_r.pix) begin
					$display("%0t: pixel_out expected %h actual %h",
						$time, exp_r.pix, m_axis_tdata);
					errors++;
				end
				if (m_axis_tlast !== exp_r.last) begin
					$display("%0t: frame_last expected %b actual %b",
						$time, exp_r.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int phase;
		int small_used;
		int start_used;
		bit extreme;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int k = 0; k < $size(DIR_TAB); k++) begin
			if (DIR_TAB[k].kind == ROW_CFG)
				write_reg(DIR_TAB[k].idx, DIR_TAB[k].val);
			else
				send_item(DIR_TAB[k].act, DIR_TAB[k].val[PIX_W-1:0], DIR_TAB[k].chk,
					DIR_TAB[k].res);
		end
		phase = 0;
		small_used = 0;
		while (small_used < RANDOM_ITEMS || phase <= 8) begin
			extreme = (phase == 2 || phase == 5 || phase == 8);
			start_used = items_used;
			run_phase(phase, extreme);
			if (!extreme) small_used += items_used - start_used;
			phase++;
		end
		hold_until_drained();
		repeat (END_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: files.f
hdl/mdew_pkg.sv
hdl/mdew_ram.sv
hdl/mdew_cfg.sv
hdl/mdew_ctrl.sv
hdl/mdew_out.sv
hdl/morphology_dilate_erode_window.sv
tb/morphology_dilate_erode_window_test.sv
